// ===== hdl/sic_pkg.sv =====
// Shared types and constants for the spectral index calculator.
// Depends on nothing; used by the top level and sic_pipe.
`timescale 1ns / 1ps

package sic_pkg;

    localparam int BAND_W  = 16;
    localparam int NUM_W   = 17;
    localparam int SUM_W   = 36;
    localparam int ROOT_W  = 18;
    localparam int RATIO_W = 24;

    localparam logic [RATIO_W-1:0] RATIO_MAX = 24'h7FFFFF;
    localparam logic [RATIO_W-1:0] RATIO_MIN = 24'h800000;

    typedef enum logic [1:0] {
        SET_VEG      = 2'd0,
        SET_RED_EDGE = 2'd1,
        SET_ALL      = 2'd2,
        SET_RSVD     = 2'd3
    } index_set_t;

    // One ratio operand pair: sign, nonzero flag and magnitude of the numerator, and the denominator
    typedef struct packed {
        logic             neg;
        logic             nz;
        logic [NUM_W-1:0] mag;
        logic [NUM_W-1:0] den;
    } div_in_t;

    // Everything the iteration pipeline needs for one request
    typedef struct packed {
        div_in_t [3:0]    div;
        logic [SUM_W-1:0] sumsq;
        logic             last;
    } front_t;

    // Finished index values of one request
    typedef struct packed {
        logic [RATIO_W-1:0] ndvi;
        logic [RATIO_W-1:0] ndwi_swir;
        logic [ROOT_W-1:0]  brightness;
        logic [RATIO_W-1:0] psri;
        logic [RATIO_W-1:0] chl_red_edge;
        logic               last;
    } res_t;

endpackage

// ===== hdl/sic_if.sv =====
// Handshake channel interfaces of the spectral index calculator.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

interface sic_band_if;
    logic        valid;
    logic        ready;
    logic [15:0] band_pos0;
    logic [15:0] band_pos1;
    logic [15:0] band_pos2;
    logic [15:0] band_pos3;
    logic [15:0] band_pos4;
    logic [15:0] band_pos5;
    logic [15:0] band_pos6;
    logic [15:0] band_pos7;
    logic [15:0] band_pos8;
    logic [15:0] band_pos9;
    logic        last_date;
    modport source (output valid, band_pos0, band_pos1, band_pos2, band_pos3, band_pos4,
                    band_pos5, band_pos6, band_pos7, band_pos8, band_pos9, last_date,
                    input ready);
    modport sink (input valid, band_pos0, band_pos1, band_pos2, band_pos3, band_pos4,
                  band_pos5, band_pos6, band_pos7, band_pos8, band_pos9, last_date,
                  output ready);
endinterface

interface sic_index_if;
    logic        valid;
    logic        ready;
    logic [23:0] ndvi;
    logic [23:0] ndwi_swir;
    logic [17:0] brightness;
    logic [23:0] psri;
    logic [23:0] chl_red_edge;
    logic        last_date_out;
    modport source (output valid, ndvi, ndwi_swir, brightness, psri, chl_red_edge,
                    last_date_out, input ready);
    modport sink (input valid, ndvi, ndwi_swir, brightness, psri, chl_red_edge,
                  last_date_out, output ready);
endinterface

interface sic_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hdl/spectral_index_calculator_core.sv =====
// Spectral index calculator top level: band input, index result and set register channels.
// Depends on sic_pkg, sic_if and sic_pipe.
`timescale 1ns / 1ps

// Use:
//   band_in carries one date of a pixel: ten 16-bit reflectances and last_date.
//   index_out returns one result per request: NDVI, SWIR NDWI, brightness, PSRI
//   and red-edge chlorophyll, ratios signed with FRAC_BITS fraction bits.
//   cfg writes the 2-bit index set; write it only while the block is empty.
//   Fields outside the chosen set read as zero.
// Timing:
//   From band_in acceptance to index_out valid: three stages form squares, sums
//   and ratio operands, one register loads the iteration pipeline, then
//   FRAC_BITS + 17 stages each retire one quotient bit of the four dividers
//   (the square root takes 18 of them), then the output register.
//   Throughput is one request per cycle while index_out does not stall.
// Reset clears all valid bits and sets the index set to all indices.
// When index_out stalls with a result held, the whole pipeline holds and
// band_in.ready drops; nothing is lost or repeated.

module spectral_index_calculator_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    sic_band_if.sink           band_in,
    sic_index_if.source        index_out,
    sic_cfg_if.sink            cfg
);

    logic                         adv;
    logic [sic_pkg::BAND_W-1:0]   b [10];
    sic_pkg::index_set_t          index_set_reg;

    logic [2*sic_pkg::BAND_W-1:0] sq_reg [10];
    sic_pkg::div_in_t [3:0]       div1_reg;
    logic                         last1_reg;
    logic                         valid1_reg;

    logic [sic_pkg::SUM_W-1:0]    half_reg [2];
    sic_pkg::div_in_t [3:0]       div2_reg;
    logic                         last2_reg;
    logic                         valid2_reg;

    sic_pkg::front_t              front_reg;
    logic                         valid3_reg;

    logic                         res_valid;
    sic_pkg::res_t                res;
    sic_pkg::res_t                out_reg;
    logic                         out_valid_reg;
    logic                         set_a;
    logic                         set_b;

    assign adv           = !out_valid_reg || index_out.ready;
    assign band_in.ready = adv;
    assign cfg.ready     = 1'b1;

    assign b[0] = band_in.band_pos0;
    assign b[1] = band_in.band_pos1;
    assign b[2] = band_in.band_pos2;
    assign b[3] = band_in.band_pos3;
    assign b[4] = band_in.band_pos4;
    assign b[5] = band_in.band_pos5;
    assign b[6] = band_in.band_pos6;
    assign b[7] = band_in.band_pos7;
    assign b[8] = band_in.band_pos8;
    assign b[9] = band_in.band_pos9;

    // Hold the index set register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_set_reg <= sic_pkg::SET_ALL;
        else if (cfg.valid && cfg.ready)
            index_set_reg <= sic_pkg::index_set_t'(cfg.data);
    end

    // Advance valid bits of the front stages and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid1_reg    <= band_in.valid;
            valid2_reg    <= valid1_reg;
            valid3_reg    <= valid2_reg;
            out_valid_reg <= res_valid;
        end
    end

    // Stage 1: square each band and form ratio operands
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 10; i++)
                sq_reg[i] <= b[i] * b[i];
            div1_reg[0].neg <= b[2] > b[6];
            div1_reg[0].nz  <= b[2] != b[6];
            div1_reg[0].mag <= (b[2] > b[6]) ? sic_pkg::NUM_W'(b[2] - b[6])
                                             : sic_pkg::NUM_W'(b[6] - b[2]);
            div1_reg[0].den <= sic_pkg::NUM_W'(b[6]) + sic_pkg::NUM_W'(b[2]);
            div1_reg[1].neg <= b[9] > b[7];
            div1_reg[1].nz  <= b[9] != b[7];
            div1_reg[1].mag <= (b[9] > b[7]) ? sic_pkg::NUM_W'(b[9] - b[7])
                                             : sic_pkg::NUM_W'(b[7] - b[9]);
            div1_reg[1].den <= sic_pkg::NUM_W'(b[7]) + sic_pkg::NUM_W'(b[9]);
            div1_reg[2].neg <= b[1] > b[2];
            div1_reg[2].nz  <= b[1] != b[2];
            div1_reg[2].mag <= (b[1] > b[2]) ? sic_pkg::NUM_W'(b[1] - b[2])
                                             : sic_pkg::NUM_W'(b[2] - b[1]);
            div1_reg[2].den <= sic_pkg::NUM_W'(b[6]);
            div1_reg[3].neg <= 1'b0;
            div1_reg[3].nz  <= b[3] != '0;
            div1_reg[3].mag <= sic_pkg::NUM_W'(b[3]);
            div1_reg[3].den <= sic_pkg::NUM_W'(b[6]);
            last1_reg       <= band_in.last_date;
        end
    end

    // Stage 2: add squares in two groups of five
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            half_reg[0] <= sic_pkg::SUM_W'(sq_reg[0]) + sic_pkg::SUM_W'(sq_reg[1])
                         + sic_pkg::SUM_W'(sq_reg[2]) + sic_pkg::SUM_W'(sq_reg[3])
                         + sic_pkg::SUM_W'(sq_reg[4]);
            half_reg[1] <= sic_pkg::SUM_W'(sq_reg[5]) + sic_pkg::SUM_W'(sq_reg[6])
                         + sic_pkg::SUM_W'(sq_reg[7]) + sic_pkg::SUM_W'(sq_reg[8])
                         + sic_pkg::SUM_W'(sq_reg[9]);
            div2_reg    <= div1_reg;
            last2_reg   <= last1_reg;
        end
    end

    // Stage 3: final sum of squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg.sumsq <= half_reg[0] + half_reg[1];
            front_reg.div   <= div2_reg;
            front_reg.last  <= last2_reg;
        end
    end

    sic_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .front_valid (valid3_reg),
        .front       (front_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Drop fields outside the chosen set into the output register
    assign set_a = index_set_reg != sic_pkg::SET_RED_EDGE;
    assign set_b = index_set_reg != sic_pkg::SET_VEG;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.ndvi         <= set_a ? res.ndvi : '0;
            out_reg.ndwi_swir    <= set_a ? res.ndwi_swir : '0;
            out_reg.brightness   <= set_a ? res.brightness : '0;
            out_reg.psri         <= set_b ? res.psri : '0;
            out_reg.chl_red_edge <= set_b ? res.chl_red_edge : '0;
            out_reg.last         <= res.last;
        end
    end

    assign index_out.valid         = out_valid_reg;
    assign index_out.ndvi          = out_reg.ndvi;
    assign index_out.ndwi_swir     = out_reg.ndwi_swir;
    assign index_out.brightness    = out_reg.brightness;
    assign index_out.psri          = out_reg.psri;
    assign index_out.chl_red_edge  = out_reg.chl_red_edge;
    assign index_out.last_date_out = out_reg.last;

    a_ready_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        band_in.ready == (!out_valid_reg || index_out.ready))
        else $error("input ready does not follow output stall");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid3_reg) && $stable(valid1_reg))
        else $error("pipeline moved during stall");

    a_veg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (index_out.valid && index_set_reg == sic_pkg::SET_VEG) |->
        (index_out.psri == '0 && index_out.chl_red_edge == '0))
        else $error("red-edge fields not cleared");

    a_ndvi_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_out.valid |->
        ($signed(index_out.ndvi) <= $signed(25'(1) <<< FRAC_BITS) &&
         $signed(index_out.ndvi) >= -($signed(25'(1) <<< FRAC_BITS))))
        else $error("ndvi outside unit range");

endmodule

// ===== hdl/sic_pipe.sv =====
// Iteration pipeline: four restoring dividers and one square root, one step per stage.
// Depends on sic_pkg.
`timescale 1ns / 1ps

module sic_pipe #(
    parameter int FRAC_BITS = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            front_valid,
    input  sic_pkg::front_t front,
    output logic            res_valid,
    output sic_pkg::res_t   res
);

    localparam int DW     = sic_pkg::NUM_W + FRAC_BITS;
    localparam int STAGES = DW;

    typedef struct packed {
        logic [DW-1:0]           dq;
        logic [sic_pkg::NUM_W-1:0] rem;
        logic [sic_pkg::NUM_W-1:0] den;
        logic                    neg;
        logic                    nz;
    } dstage_t;

    typedef struct packed {
        dstage_t [3:0]              d;
        logic [sic_pkg::SUM_W-1:0]  sv;
        logic [sic_pkg::ROOT_W+1:0] srem;
        logic [sic_pkg::ROOT_W-1:0] root;
        logic                       last;
    } stage_t;

    function automatic dstage_t div_step(input dstage_t s);
        logic [sic_pkg::NUM_W:0] trial;
        dstage_t                 r;
        r     = s;
        trial = {s.rem, s.dq[DW-1]};
        if (trial >= {1'b0, s.den})
        begin
            r.rem = sic_pkg::NUM_W'(trial - {1'b0, s.den});
            r.dq  = {s.dq[DW-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[sic_pkg::NUM_W-1:0];
            r.dq  = {s.dq[DW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic stage_t sqrt_step(input stage_t s);
        logic [sic_pkg::ROOT_W+3:0] sh;
        logic [sic_pkg::ROOT_W+3:0] trial;
        stage_t                     r;
        r     = s;
        sh    = {s.srem, s.sv[sic_pkg::SUM_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        r.sv  = {s.sv[sic_pkg::SUM_W-3:0], 2'b00};
        if (sh >= trial)
        begin
            r.srem = (sic_pkg::ROOT_W+2)'(sh - trial);
            r.root = {s.root[sic_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.srem = sh[sic_pkg::ROOT_W+1:0];
            r.root = {s.root[sic_pkg::ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Saturate a quotient magnitude into a signed ratio
    function automatic logic [sic_pkg::RATIO_W-1:0] sat(input dstage_t s);
        logic [sic_pkg::RATIO_W-1:0] v;
        v = '0;
        if (!s.nz)
            v = '0;
        else if (!s.neg)
            v = (s.dq > DW'(sic_pkg::RATIO_MAX)) ? sic_pkg::RATIO_MAX
                                                  : s.dq[sic_pkg::RATIO_W-1:0];
        else
            v = (s.dq > DW'(sic_pkg::RATIO_MIN)) ? sic_pkg::RATIO_MIN
                                                  : sic_pkg::RATIO_W'(-s.dq[sic_pkg::RATIO_W-1:0]);
        return v;
    endfunction

    stage_t             stage_reg [0:STAGES];
    logic [0:STAGES]    valid_reg;
    stage_t             load;

    // Build the first stage from the front request
    always_comb
    begin
        load = '0;
        for (int i = 0; i < 4; i++)
        begin
            load.d[i].dq  = {front.div[i].mag, {FRAC_BITS{1'b0}}};
            load.d[i].den = front.div[i].den;
            load.d[i].neg = front.div[i].neg;
            load.d[i].nz  = front.div[i].nz;
        end
        load.sv   = front.sumsq;
        load.last = front.last;
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {front_valid, valid_reg[0:STAGES-1]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg[0] <= load;
    end

    genvar k;
    generate
        for (k = 1; k <= STAGES; k++)
        begin : g_stage
            stage_t step_next;
            always_comb
            begin
                step_next = stage_reg[k-1];
                if (k <= sic_pkg::ROOT_W)
                    step_next = sqrt_step(stage_reg[k-1]);
                for (int i = 0; i < 4; i++)
                    step_next.d[i] = div_step(stage_reg[k-1].d[i]);
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                    stage_reg[k] <= step_next;
            end
        end
    endgenerate

    // Finish the last stage into index values
    assign res_valid        = valid_reg[STAGES];
    assign res.ndvi         = sat(stage_reg[STAGES].d[0]);
    assign res.ndwi_swir    = sat(stage_reg[STAGES].d[1]);
    assign res.psri         = sat(stage_reg[STAGES].d[2]);
    assign res.chl_red_edge = sat(stage_reg[STAGES].d[3]);
    assign res.brightness   = stage_reg[STAGES].root;
    assign res.last         = stage_reg[STAGES].last;

endmodule
